// ===== src/cdq_pkg.sv =====
package cdq_pkg;

	localparam int DEPTH = 16;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int VW    = 32;

	typedef logic [AW-1:0] idx_t;

	typedef enum logic [1:0] {
		OP_PUSH_BACK  = 2'd0,
		OP_PUSH_FRONT = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		opcode_t               opcode;
		logic signed [VW-1:0]  push_value;
	} in_item_t;

	typedef struct packed {
		status_t               status;
		logic signed [VW-1:0]  popped_value;
		logic                  is_empty;
		logic                  is_full;
	} out_item_t;

	// memory access issued in the cycle an item is accepted
	typedef struct packed {
		logic          en;
		logic          we;
		idx_t          addr;
		logic [VW-1:0] wdata;
	} mem_req_t;

	// result of an item, waiting in the read stage for the read data
	typedef struct packed {
		logic    valid;
		logic    pop_ok;
		status_t status;
		logic    is_empty;
		logic    is_full;
	} res_info_t;

	function automatic idx_t idx_next(input idx_t i);
		return (i == idx_t'(DEPTH - 1)) ? '0 : idx_t'(i + idx_t'(1));
	endfunction

	function automatic idx_t idx_prev(input idx_t i);
		return (i == '0) ? idx_t'(DEPTH - 1) : idx_t'(i - idx_t'(1));
	endfunction

endpackage

// ===== src/circular_deque.sv =====
// channel  | valid     | ready     | payload
// in       | in_valid  | in_ready  | in_data  (opcode, push_value)
// out      | out_valid | out_ready | out_data (status, popped_value, is_empty, is_full)
//
// One item per cycle unless the input stalls; a result goes to the output register:
// the slot is read at the accepting edge; the read stage then loads it on advancing.
// Pointers and the empty flag live in registers; slots live in a single-port memory.
// arst_n clears the pointers and marks the deque empty; the slot store is not cleared.
// A stalled output holds the waiting result and the read stage;
// input stalls only when both are full and the output is not taken.
module circular_deque (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cdq_pkg::in_item_t    in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cdq_pkg::out_item_t   out_data
);

	cdq_pkg::mem_req_t   mem_req;
	cdq_pkg::res_info_t  info_s1;
	logic [cdq_pkg::VW-1:0] rdata;
	logic                accept;
	logic                advance;
	logic                out_valid_q;
	cdq_pkg::out_item_t  out_data_q;

	assign advance  = info_s1.valid && (!out_valid_q || out_ready);
	assign in_ready = !info_s1.valid || advance;
	assign accept   = in_valid && in_ready;

	cdq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (in_data),
		.advance (advance),
		.mem_req (mem_req),
		.info_s1 (info_s1)
	);

	cdq_ram #(
		.Depth (cdq_pkg::DEPTH),
		.Width (cdq_pkg::VW)
	) u_ram (
		.clk   (clk),
		.en    (mem_req.en),
		.we    (mem_req.we),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q.status       <= info_s1.status;
			out_data_q.popped_value <= info_s1.pop_ok ? rdata : '0;
			out_data_q.is_empty     <= info_s1.is_empty;
			out_data_q.is_full      <= info_s1.is_full;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef NO_ASSERTIONS
	a_zero_on_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.status != cdq_pkg::ST_OK))
		|-> (out_data.popped_value == '0))
		else $error("refused item returned a value");

	a_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.is_empty && out_data.is_full))
		else $error("deque reported empty and full together");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(info_s1.valid && !advance) |=> info_s1.valid)
		else $error("read stage dropped a stalled item");
`endif

endmodule

// ===== src/cdq_ram.sv =====
module cdq_ram #(
	parameter int Depth = 16,
	parameter int Width = 32
) (
	input  logic                                    clk,
	input  logic                                    en,
	input  logic                                    we,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr,
	input  logic [Width-1:0]                        wdata,
	output logic [Width-1:0]                        rdata
);

	logic [Width-1:0] mem [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/cdq_ctrl.sv =====
module cdq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  cdq_pkg::in_item_t   item,
	input  logic                advance,
	output cdq_pkg::mem_req_t   mem_req,
	output cdq_pkg::res_info_t  info_s1
);

	cdq_pkg::idx_t head_q, tail_q, head_d, tail_d;
	logic          empty_q, empty_d;
	logic          full;
	logic          is_push;
	cdq_pkg::res_info_t info_d;
	cdq_pkg::mem_req_t  req;

	assign full    = !empty_q && (cdq_pkg::idx_next(tail_q) == head_q);
	assign is_push = (item.opcode == cdq_pkg::OP_PUSH_BACK) ||
	                 (item.opcode == cdq_pkg::OP_PUSH_FRONT);

	always_comb begin
		head_d         = head_q;
		tail_d         = tail_q;
		empty_d        = empty_q;
		req.en         = 1'b0;
		req.we         = 1'b0;
		req.addr       = head_q;
		req.wdata      = item.push_value;
		info_d.valid   = 1'b1;
		info_d.pop_ok  = 1'b0;
		info_d.status  = cdq_pkg::ST_OK;

		if (is_push) begin
			if (full) begin
				info_d.status = cdq_pkg::ST_OVERFLOW;
			end else if (empty_q) begin
				head_d   = '0;
				tail_d   = '0;
				empty_d  = 1'b0;
				req.en   = 1'b1;
				req.we   = 1'b1;
				req.addr = '0;
			end else if (item.opcode == cdq_pkg::OP_PUSH_BACK) begin
				tail_d   = cdq_pkg::idx_next(tail_q);
				req.en   = 1'b1;
				req.we   = 1'b1;
				req.addr = tail_d;
			end else begin
				head_d   = cdq_pkg::idx_prev(head_q);
				req.en   = 1'b1;
				req.we   = 1'b1;
				req.addr = head_d;
			end
		end else begin
			if (empty_q) begin
				info_d.status = cdq_pkg::ST_UNDERFLOW;
			end else begin
				info_d.pop_ok = 1'b1;
				req.en        = 1'b1;
				if (head_q == tail_q) begin
					// last entry leaves: return both pointers to slot 0
					req.addr = head_q;
					head_d   = '0;
					tail_d   = '0;
					empty_d  = 1'b1;
				end else if (item.opcode == cdq_pkg::OP_POP_FRONT) begin
					req.addr = head_q;
					head_d   = cdq_pkg::idx_next(head_q);
				end else begin
					req.addr = tail_q;
					tail_d   = cdq_pkg::idx_prev(tail_q);
				end
			end
		end

		info_d.is_empty = empty_d;
		info_d.is_full  = !empty_d && (cdq_pkg::idx_next(tail_d) == head_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q        <= '0;
			tail_q        <= '0;
			empty_q       <= 1'b1;
			info_s1.valid <= 1'b0;
		end else if (accept) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			empty_q <= empty_d;
			info_s1 <= info_d;
		end else if (advance) begin
			info_s1.valid <= 1'b0;
		end
	end

	always_comb begin
		mem_req    = req;
		mem_req.en = req.en && accept;
	end

`ifndef NO_ASSERTIONS
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (head_q == '0) && (tail_q == '0))
		else $error("empty deque with nonzero pointers");

	a_refused_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ((is_push && full) || (!is_push && empty_q)))
		|=> $stable(head_q) && $stable(tail_q) && $stable(empty_q))
		else $error("refused item changed the pointers");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(head_q) < cdq_pkg::DEPTH) && (32'(tail_q) < cdq_pkg::DEPTH))
		else $error("pointer beyond the store");
`endif

endmodule

// ===== sim/tb_circular_deque.sv =====
module tb_circular_deque;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 1625;
	localparam int SETTLE_CYCLES = 8;
	localparam int IDLE_PCT      = 28;

	typedef struct {
		cdq_pkg::in_item_t item;
		bit                drain_first;
	} stim_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	cdq_pkg::in_item_t  in_data   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	cdq_pkg::out_item_t out_data;

	stim_t              pending_items[$];
	cdq_pkg::out_item_t expected_results[$];

	int errors        = 0;
	int sent_count    = 0;
	int checked_count = 0;
	int cycle_count   = 0;
	int n_push        = 0;
	int n_pop         = 0;
	int n_overflow    = 0;
	int n_underflow   = 0;

	// mirror of the deque contents
	logic [cdq_pkg::VW-1:0] mirror_slot [cdq_pkg::DEPTH];
	cdq_pkg::idx_t          mirror_head;
	cdq_pkg::idx_t          mirror_tail;
	logic                   mirror_empty;

	circular_deque uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	function automatic cdq_pkg::idx_t step_fwd(input cdq_pkg::idx_t i);
		return cdq_pkg::idx_t'((int'(i) + 1) % cdq_pkg::DEPTH);
	endfunction

	function automatic cdq_pkg::idx_t step_back(input cdq_pkg::idx_t i);
		return cdq_pkg::idx_t'((int'(i) + cdq_pkg::DEPTH - 1) % cdq_pkg::DEPTH);
	endfunction

	function automatic logic mirror_full();
		return !mirror_empty && step_fwd(mirror_tail) == mirror_head;
	endfunction

	// apply one item to the mirror and return the result it must produce
	function automatic cdq_pkg::out_item_t deque_apply(input cdq_pkg::in_item_t it);
		cdq_pkg::out_item_t r;
		r.status       = cdq_pkg::ST_OK;
		r.popped_value = '0;
		case (it.opcode)
			cdq_pkg::OP_PUSH_BACK, cdq_pkg::OP_PUSH_FRONT: begin
				if (mirror_full()) begin
					r.status = cdq_pkg::ST_OVERFLOW;
				end else if (mirror_empty) begin
					mirror_head    = '0;
					mirror_tail    = '0;
					mirror_empty   = 1'b0;
					mirror_slot[0] = it.push_value;
				end else if (it.opcode == cdq_pkg::OP_PUSH_BACK) begin
					mirror_tail              = step_fwd(mirror_tail);
					mirror_slot[mirror_tail] = it.push_value;
				end else begin
					mirror_head              = step_back(mirror_head);
					mirror_slot[mirror_head] = it.push_value;
				end
			end
			default: begin
				if (mirror_empty) begin
					r.status = cdq_pkg::ST_UNDERFLOW;
				end else if (mirror_head == mirror_tail) begin
					r.popped_value = mirror_slot[mirror_head];
					mirror_head    = '0;
					mirror_tail    = '0;
					mirror_empty   = 1'b1;
				end else if (it.opcode == cdq_pkg::OP_POP_FRONT) begin
					r.popped_value = mirror_slot[mirror_head];
					mirror_head    = step_fwd(mirror_head);
				end else begin
					r.popped_value = mirror_slot[mirror_tail];
					mirror_tail    = step_back(mirror_tail);
				end
			end
		endcase
		r.is_empty = mirror_empty;
		r.is_full  = mirror_full();
		return r;
	endfunction

	// window with no idling on either side
	function automatic bit steady_window(input int n);
		return n >= 700 && n < 1000;
	endfunction

	task automatic add_item(input cdq_pkg::opcode_t op, input logic [cdq_pkg::VW-1:0] v,
			input bit drain);
		stim_t s;
		s.item.opcode     = op;
		s.item.push_value = v;
		s.drain_first     = drain;
		pending_items     = {pending_items, s};
	endtask

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d results still expected",
			cycle_count, expected_results.size());
		$display("DONE: errors detected");
		$finish;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin : drive
			logic               fire;
			stim_t              nxt;
			cdq_pkg::out_item_t r;
			fire = in_valid && in_ready;
			if (fire) begin
				r = deque_apply(in_data);
				expected_results = {expected_results, r};
				sent_count++;
				if (r.status == cdq_pkg::ST_OVERFLOW)
					n_overflow++;
				else if (r.status == cdq_pkg::ST_UNDERFLOW)
					n_underflow++;
				else if (in_data.opcode == cdq_pkg::OP_PUSH_BACK
						|| in_data.opcode == cdq_pkg::OP_PUSH_FRONT)
					n_push++;
				else
					n_pop++;
			end
			if (in_valid && !fire) begin
				// hold the item until it is taken
			end else if (pending_items.size() > 0
					&& (steady_window(sent_count) || $urandom_range(99) >= IDLE_PCT)
					&& (!pending_items[0].drain_first
						|| (!fire && expected_results.size() == 0))) begin
				nxt = pending_items[0];
				pending_items.delete(0);
				in_valid <= 1'b1;
				in_data  <= nxt.item;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin : watch
			cdq_pkg::out_item_t want;
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: status %0d popped %h empty %b full %b",
						$time, out_data.status, out_data.popped_value,
						out_data.is_empty, out_data.is_full);
				end else begin
					want = expected_results[0];
					expected_results.delete(0);
					checked_count++;
					if (out_data.status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, out_data.status);
					end
					if (out_data.popped_value !== want.popped_value) begin
						errors++;
						$display("%0t: popped_value expected %h actual %h",
							$time, want.popped_value, out_data.popped_value);
					end
					if (out_data.is_empty !== want.is_empty) begin
						errors++;
						$display("%0t: is_empty expected %b actual %b",
							$time, want.is_empty, out_data.is_empty);
					end
					if (out_data.is_full !== want.is_full) begin
						errors++;
						$display("%0t: is_full expected %b actual %b",
							$time, want.is_full, out_data.is_full);
					end
				end
			end
			out_ready <= steady_window(checked_count) || $urandom_range(99) >= IDLE_PCT;
		end
	end

	initial begin
		logic [cdq_pkg::VW-1:0] extremes [4];
		logic [cdq_pkg::VW-1:0] v;
		int                     n;
		int                     burst;
		int                     push_pct;

		extremes[0] = 32'h0000_0000;
		extremes[1] = 32'hFFFF_FFFF;
		extremes[2] = 32'h8000_0000;
		extremes[3] = 32'h7FFF_FFFF;

		mirror_head  = '0;
		mirror_tail  = '0;
		mirror_empty = 1'b1;

		// pops on the empty deque
		add_item(cdq_pkg::OP_POP_FRONT, 32'h1234_5678, 1'b0);
		add_item(cdq_pkg::OP_POP_BACK, 32'hFFFF_FFFF, 1'b0);
		// push into empty, then empty it again from both ends
		add_item(cdq_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF, 1'b0);
		add_item(cdq_pkg::OP_PUSH_FRONT, 32'h8000_0000, 1'b0);
		add_item(cdq_pkg::OP_POP_BACK, 32'h0, 1'b0);
		add_item(cdq_pkg::OP_POP_FRONT, 32'h0, 1'b0);
		// fill from both ends, wrapping the head below slot zero
		for (int i = 0; i < cdq_pkg::DEPTH; i++) begin
			case (i)
				0: v = 32'hFFFF_FFFF;
				1: v = 32'h0000_0000;
				2: v = 32'h5555_5555;
				3: v = 32'hAAAA_AAAA;
				default: v = $urandom;
			endcase
			add_item((i % 2) ? cdq_pkg::OP_PUSH_FRONT : cdq_pkg::OP_PUSH_BACK, v, 1'b0);
		end
		// both pushes refused while full
		add_item(cdq_pkg::OP_PUSH_BACK, 32'h0BAD_0001, 1'b0);
		add_item(cdq_pkg::OP_PUSH_FRONT, 32'h0BAD_0002, 1'b0);

		// bursts leaning toward pushes or pops sweep between empty and full
		n = 0;
		while (n < RANDOM_ITEMS) begin
			burst = $urandom_range(60, 20);
			case ($urandom_range(2))
				0: push_pct = 80;
				1: push_pct = 50;
				default: push_pct = 20;
			endcase
			for (int k = 0; k < burst && n < RANDOM_ITEMS; k++) begin
				v = ($urandom_range(7) == 0) ? extremes[$urandom_range(3)] : $urandom;
				if ($urandom_range(99) < push_pct)
					add_item(cdq_pkg::opcode_t'($urandom_range(1)), v, n % 400 == 0);
				else
					add_item(cdq_pkg::opcode_t'(2 + $urandom_range(1)), v, n % 400 == 0);
				n++;
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() > 0 || in_valid) @(posedge clk);
		while (expected_results.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d items: %0d pushes, %0d pops, %0d refused on full, %0d on empty.",
			sent_count, n_push, n_pop, n_overflow, n_underflow);
		$display("Checked %0d results in %0d cycles.", checked_count, cycle_count);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/cdq_pkg.sv
src/cdq_ram.sv
src/cdq_ctrl.sv
src/circular_deque.sv
sim/tb_circular_deque.sv
